// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked on the following edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// types and register codes of the streaming substring replace block
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_line_end;
    logic       run_last;
  } out_item_t;

endpackage

// ===== rtl/stream_substring_replace.sv =====
// ----------------------------------------------------------------------------
// stream_substring_replace
// byte stream find and replace with per-line window flush
// ----------------------------------------------------------------------------
// Each accepted input transaction is held in an input register; one pass of
// combinational logic compares the window plus the new byte against the
// pattern, updates the window and loads the complete list of results for
// that transaction (up to max(MAX_PATTERN, MAX_REPLACEMENT) + 1 entries) into
// a result shift register whose head drives the output port. A transaction
// that causes zero or one result streams at one per cycle while the output
// is not stalled; a transaction that causes N results occupies the result
// shift register until all N are taken and holds off the next item until
// its last result is taken. There is no clearing pass after reset.
// Configuration writes are always taken (cfg_ready is high) and must only
// arrive while the block is idle; writing the pattern length discards the window contents.
module stream_substring_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ssr_pkg::in_item_t            in_data,
  // result stream
  output logic                         out_valid,
  input  logic                         out_stall,
  output ssr_pkg::out_item_t           out_data,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssr_pkg::*;

  localparam int WIN_CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int REP_CNT_W = $clog2(MAX_REPLACEMENT + 1);
  localparam int RUN_DEPTH = ((MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                               : MAX_REPLACEMENT) + 1;
  localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 1);

  // configuration registers
  logic [3:0]            pattern_length_r;
  logic [CFG_DATA_W-1:0] pattern_bytes_r;
  logic [3:0]            replacement_length_r;
  logic [CFG_DATA_W-1:0] replacement_bytes_r;

  // input register
  logic     in_valid_r;
  in_item_t in_r;

  // window of undecided bytes (contents undefined until written)
  logic [7:0]           window_r [MAX_PATTERN];
  logic [WIN_CNT_W-1:0] win_cnt_r;
  logic [WIN_CNT_W-1:0] win_cnt_nxt;

  // result shift register, head entry drives the output
  out_item_t            run_r [RUN_DEPTH];
  logic [RUN_CNT_W-1:0] run_cnt_r;
  out_item_t            run_nxt [RUN_DEPTH];
  logic [RUN_CNT_W-1:0] run_len;

  // datapath signals
  logic [WIN_CNT_W-1:0] plen_eff;
  logic [REP_CNT_W-1:0] rlen_eff;
  logic [7:0]           wb_ext [MAX_PATTERN];
  logic                 append;
  logic [WIN_CNT_W-1:0] ext_cnt;
  logic                 all_eq;
  logic                 decide;
  logic                 matched;
  logic                 shift_out;
  logic [RUN_CNT_W-1:0] n_bytes;

  // handshake
  logic out_take;
  logic run_free;
  logic load;
  logic in_take;
  logic cfg_take;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;

  assign out_valid = (run_cnt_r != '0);
  assign out_data  = run_r[0];
  assign out_take  = out_valid & ~out_stall;

  // result register can take a new run when empty or draining its last entry
  assign run_free = (run_cnt_r == '0) ||
                    ((run_cnt_r == RUN_CNT_W'(1)) && out_take);
  assign load     = in_valid_r & run_free;
  assign in_stall = in_valid_r & ~run_free;
  assign in_take  = in_valid & ~in_stall;

  // effective lengths: zero pattern length acts as one, both saturate
  always_comb begin
    if (pattern_length_r == 4'd0) begin
      plen_eff = WIN_CNT_W'(1);
    end else if (pattern_length_r > 4'(MAX_PATTERN)) begin
      plen_eff = WIN_CNT_W'(MAX_PATTERN);
    end else begin
      plen_eff = WIN_CNT_W'(pattern_length_r);
    end
    if (replacement_length_r > 4'(MAX_REPLACEMENT)) begin
      rlen_eff = REP_CNT_W'(MAX_REPLACEMENT);
    end else begin
      rlen_eff = REP_CNT_W'(replacement_length_r);
    end
  end

  // window with the incoming byte placed behind the held ones
  assign append  = in_r.byte_present && (win_cnt_r < WIN_CNT_W'(MAX_PATTERN));
  assign ext_cnt = win_cnt_r + WIN_CNT_W'(append);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wb_ext[i] = (append && (win_cnt_r == WIN_CNT_W'(i))) ? in_r.data_byte
                                                           : window_r[i];
    end
  end

  // compare the first plen window bytes with the pattern
  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((WIN_CNT_W'(i) < plen_eff) && (wb_ext[i] != pattern_bytes_r[8*i +: 8])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign decide    = in_r.byte_present && (ext_cnt >= plen_eff);
  assign matched   = decide & all_eq;
  assign shift_out = decide & ~all_eq;

  // byte results ahead of the optional line-end marker
  always_comb begin
    priority if (matched) begin
      n_bytes = RUN_CNT_W'(rlen_eff);
    end else if (in_r.end_of_line) begin
      n_bytes = RUN_CNT_W'(ext_cnt);
    end else if (shift_out) begin
      n_bytes = RUN_CNT_W'(1);
    end else begin
      n_bytes = '0;
    end
  end

  assign run_len = n_bytes + RUN_CNT_W'(in_r.end_of_line);

  // build the full result list of this transaction
  always_comb begin
    for (int k = 0; k < RUN_DEPTH; k++) begin
      run_nxt[k] = '0;
      if (RUN_CNT_W'(k) < n_bytes) begin
        run_nxt[k].out_has_byte = 1'b1;
        if (matched) begin
          if (k < MAX_REPLACEMENT) begin
            run_nxt[k].out_byte = replacement_bytes_r[8*k +: 8];
          end
        end else if (k < MAX_PATTERN) begin
          // no match: bytes leave in window order
          run_nxt[k].out_byte = wb_ext[k];
        end
      end else if (in_r.end_of_line && (RUN_CNT_W'(k) == n_bytes)) begin
        run_nxt[k].out_line_end = 1'b1;
      end
      run_nxt[k].run_last = (RUN_CNT_W'(k + 1) == run_len);
    end
  end

  // window count after this transaction
  always_comb begin
    priority if (in_r.end_of_line || matched) begin
      win_cnt_nxt = '0;
    end else if (shift_out) begin
      win_cnt_nxt = ext_cnt - WIN_CNT_W'(1);
    end else begin
      win_cnt_nxt = ext_cnt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r     <= 4'd1;
      pattern_bytes_r      <= '0;
      replacement_length_r <= 4'd0;
      replacement_bytes_r  <= '0;
      in_valid_r           <= 1'b0;
      win_cnt_r            <= '0;
      run_cnt_r            <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (load) begin
        run_cnt_r <= run_len;
      end else if (out_take) begin
        run_cnt_r <= run_cnt_r - RUN_CNT_W'(1);
      end
      // a pattern length write discards the window
      if (cfg_take && (cfg_index == CFG_PATTERN_LENGTH)) begin
        win_cnt_r <= '0;
      end else if (load) begin
        win_cnt_r <= win_cnt_nxt;
      end
      if (cfg_take) begin
        unique case (cfg_index)
          CFG_PATTERN_LENGTH:     pattern_length_r     <= cfg_data[3:0];
          CFG_PATTERN_BYTES:      pattern_bytes_r      <= cfg_data;
          CFG_REPLACEMENT_LENGTH: replacement_length_r <= cfg_data[3:0];
          CFG_REPLACEMENT_BYTES:  replacement_bytes_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (load) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (shift_out && (i < MAX_PATTERN - 1)) begin
          window_r[i] <= wb_ext[(i + 1) % MAX_PATTERN];
        end else begin
          window_r[i] <= wb_ext[i];
        end
      end
      run_r <= run_nxt;
    end else if (out_take) begin
      for (int k = 0; k < RUN_DEPTH - 1; k++) begin
        run_r[k] <= run_r[k + 1];
      end
    end
  end

endmodule

// ===== rtl/ssr_checker.sv =====
// ----------------------------------------------------------------------------
// ssr_checker
// port-level checks of the streaming substring replace block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ssr_pkg::out_item_t out_data
);
  import ssr_pkg::*;

  // a held result transaction does not change
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // input backpressure only while results are still pending
  `ASSERT_ALWAYS(a_stall_needs_run, clk, rst_n, !(in_valid && in_stall) || out_valid)

  // a result carries a byte or is the line-end marker, never both or neither
  `ASSERT_ALWAYS(a_kind, clk, rst_n, !out_valid || (out_data.out_has_byte != out_data.out_line_end))

  // the line-end marker always closes the run of its transaction
  `ASSERT_ALWAYS(a_marker_last, clk, rst_n, !(out_valid && out_data.out_line_end) || out_data.run_last)

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming substring replace block
// ----------------------------------------------------------------------------
// A queue of pending input transactions feeds a clocked driver. A clocked
// monitor predicts the results of every accepted transaction and checks
// each result field by field. A directed opening covers the special cases,
// then randomized phases cover many register settings.
module testbench;
  import ssr_pkg::*;

  localparam int MAX_PAT     = 8;
  localparam int MAX_REP     = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_GAP  = 16;
  localparam int IDLE_PCT    = 24;

  // indexes past the register list, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST         = 3'd7;

  typedef struct {
    in_item_t item;
    bit       hold;   // wait for every pending result before sending
  } text_entry_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  text_entry_t text_in_q[$];    // transactions waiting for the driver
  out_item_t   text_out_q[$];   // predicted results, oldest first
  text_entry_t drv_entry;
  logic        in_taken = 1'b0; // the current input transaction was accepted
  bit          idling_on = 1'b1;
  int          mismatches = 0;
  int          cycle_cnt = 0;

  // mirror of the configuration registers and the match window
  logic [3:0]  pat_len_raw = 4'd1;
  logic [63:0] pat_bytes   = '0;
  logic [3:0]  rep_len_raw = 4'd0;
  logic [63:0] rep_bytes   = '0;
  logic [7:0]  win [MAX_PAT];
  int          win_cnt = 0;

  stream_substring_replace u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // zero counts as one, anything above the window size saturates
  function automatic int eff_pat_len();
    if (pat_len_raw == 4'd0) return 1;
    if (pat_len_raw > MAX_PAT) return MAX_PAT;
    return int'(pat_len_raw);
  endfunction

  function automatic void push_result(logic [7:0] b, logic has, logic eol);
    out_item_t r;
    r.out_byte     = b;
    r.out_has_byte = has;
    r.out_line_end = eol;
    r.run_last     = 1'b0;
    text_out_q.push_back(r);
  endfunction

  // expected results of one accepted input transaction
  function automatic void replace_predict(in_item_t it);
    int        plen;
    int        rlen;
    int        first;
    int        i;
    logic      hit;
    out_item_t r;
    first = text_out_q.size();
    plen  = eff_pat_len();
    if (it.byte_present) begin
      if (win_cnt < MAX_PAT) begin
        win[win_cnt] = it.data_byte;
        win_cnt++;
      end
      if (win_cnt >= plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          // full match: emit the replacement and start over
          rlen = (rep_len_raw > MAX_REP) ? MAX_REP : int'(rep_len_raw);
          for (i = 0; i < rlen; i++) push_result(rep_bytes[8*i +: 8], 1'b1, 1'b0);
          win_cnt = 0;
        end else begin
          // no match: the oldest byte can no longer start one
          push_result(win[0], 1'b1, 1'b0);
          for (i = 0; i < MAX_PAT - 1; i++) win[i] = win[i+1];
          win_cnt--;
        end
      end
    end
    if (it.end_of_line) begin
      // flush the undecided bytes, then the line marker
      for (i = 0; i < win_cnt; i++) push_result(win[i], 1'b1, 1'b0);
      win_cnt = 0;
      push_result(8'h00, 1'b0, 1'b1);
    end
    if (text_out_q.size() > first) begin
      r = text_out_q.pop_back();
      r.run_last = 1'b1;
      text_out_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one pending transaction at a time, changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // a held transaction waits until every earlier result has drained
      if (text_in_q.size() != 0 && !(text_in_q[0].hold && text_out_q.size() != 0) &&
          !(idling_on && $urandom_range(99) < IDLE_PCT)) begin
        drv_entry = text_in_q.pop_front();
        in_data  <= drv_entry.item;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_stall <= rst_n && idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // monitor: check results first so a same-edge prediction cannot be popped
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (text_out_q.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          mismatches++;
        end else begin
          out_item_t want;
          want = text_out_q.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("out_has_byte", 8'(want.out_has_byte), 8'(out_data.out_has_byte));
          check_field("out_line_end", 8'(want.out_line_end), 8'(out_data.out_line_end));
          check_field("run_last", 8'(want.run_last), 8'(out_data.run_last));
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) replace_predict(in_data);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [7:0] b, logic present, logic eol, bit hold);
    text_entry_t e;
    e.item.data_byte    = b;
    e.item.byte_present = present;
    e.item.end_of_line  = eol;
    e.hold              = hold;
    text_in_q.push_back(e);
  endtask

  // register write; the mirror follows at the edge that takes it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PATTERN_LENGTH: begin
        pat_len_raw = val[3:0];
        win_cnt     = 0;
      end
      CFG_PATTERN_BYTES:      pat_bytes   = val;
      CFG_REPLACEMENT_LENGTH: rep_len_raw = val[3:0];
      CFG_REPLACEMENT_BYTES:  rep_bytes   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for the block to go idle, with slack for items that give no result
  task automatic settle();
    while (text_in_q.size() != 0 || in_valid || text_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic random_config();
    logic [63:0] v;
    int          r;
    r = $urandom_range(99);
    v = {$urandom, $urandom};
    if ($urandom_range(3) != 0) v[63:4] = '0;
    if (r < 10) v[3:0] = 4'd0;
    else if (r < 20) v[3:0] = 4'($urandom_range(15, 9));
    else if (r < 35) v[3:0] = 4'd8;
    else v[3:0] = 4'($urandom_range(4, 1));
    write_reg(CFG_PATTERN_LENGTH, v);
    write_reg(CFG_PATTERN_BYTES, {$urandom, $urandom});
    v = {$urandom, $urandom};
    if ($urandom_range(3) != 0) v[63:4] = '0;
    if ($urandom_range(3) != 0) v[3:0] = 4'($urandom_range(8, 0));
    write_reg(CFG_REPLACEMENT_LENGTH, v);
    write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
    if ($urandom_range(2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_LAST, CFG_IDX_FIRST_UNUSED)),
                {$urandom, $urandom});
  endtask

  // lines built mostly from the pattern so matches, near misses and
  // overlaps are frequent; some raw bytes, line ends and empty items
  task automatic queue_random_text(int n_items);
    int made;
    int plen;
    int k;
    int span;
    int r;
    made = 0;
    plen = eff_pat_len();
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 30) begin
        // whole occurrence, or sometimes only a prefix of one
        span = ($urandom_range(3) == 0) ? $urandom_range(plen, 1) : plen;
        for (k = 0; k < span; k++)
          queue_item(pat_bytes[8*k +: 8], 1'b1, 1'b0, $urandom_range(99) < 3);
        made += span;
      end else if (r < 55) begin
        k = $urandom_range(plen - 1, 0);
        queue_item(pat_bytes[8*k +: 8], 1'b1, 1'b0, $urandom_range(99) < 3);
        made++;
      end else if (r < 75) begin
        queue_item(8'($urandom_range(255, 0)), 1'b1, 1'b0, $urandom_range(99) < 3);
        made++;
      end else if (r < 85) begin
        queue_item(8'($urandom_range(255, 0)), 1'b1, 1'b1, $urandom_range(99) < 3);
        made++;
      end else if (r < 94) begin
        queue_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, $urandom_range(99) < 3);
        made++;
      end else begin
        // empty item, ignored by the block
        queue_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one byte pattern 00, deleted without replacement
    queue_item(8'h00, 1'b1, 1'b0, 1'b0);
    queue_item(8'hff, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0, 1'b0);   // empty item
    queue_item(8'h5a, 1'b1, 1'b1, 1'b0);   // byte with line end
    queue_item(8'hff, 1'b0, 1'b1, 1'b0);   // bare line end
    settle();

    // index past the register list changes nothing
    write_reg(CFG_IDX_LAST, 64'h0123_4567_89ab_cdef);

    // three byte pattern, full eight byte replacement
    write_reg(CFG_PATTERN_LENGTH, 64'd3);
    write_reg(CFG_PATTERN_BYTES, 64'hffee_ddcc_bb63_6261);
    write_reg(CFG_REPLACEMENT_LENGTH, 64'd8);
    write_reg(CFG_REPLACEMENT_BYTES, 64'h3837_3635_3433_3231);
    queue_item(8'h78, 1'b1, 1'b0, 1'b0);
    queue_item(8'h61, 1'b1, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    queue_item(8'h63, 1'b1, 1'b0, 1'b0);
    queue_item(8'h61, 1'b1, 1'b0, 1'b1);   // sender drains first
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1, 1'b0);   // replacement plus marker
    queue_item(8'h61, 1'b1, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b1);   // flush of a partial match
    settle();

    // partial window, then a pattern length rewrite discards it
    write_reg(CFG_PATTERN_LENGTH, 64'd4);
    queue_item(8'h61, 1'b1, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    settle();
    write_reg(CFG_PATTERN_LENGTH, 64'd0);          // counts as one
    write_reg(CFG_PATTERN_BYTES, 64'h7a);
    write_reg(CFG_REPLACEMENT_LENGTH, 64'd15);     // saturates
    queue_item(8'h7a, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    settle();

    // oversize pattern length saturates, deletion of an eight byte match
    write_reg(CFG_PATTERN_LENGTH, 64'hffff_ffff_ffff_fffc);
    write_reg(CFG_PATTERN_BYTES, 64'hf7f6_f5f4_f3f2_f1f0);
    write_reg(CFG_REPLACEMENT_LENGTH, 64'd0);
    for (int k = 0; k < MAX_PAT; k++)
      queue_item(8'hf0 + 8'(k), 1'b1, k == MAX_PAT - 1, 1'b0);
    settle();

    // random phases, one of them without any idling
    for (ph = 0; ph < 6; ph++) begin
      idling_on = (ph != 2);
      random_config();
      queue_random_text(28);
      settle();
    end

    if (mismatches == 0 && text_out_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssr_pkg.sv
rtl/stream_substring_replace.sv
rtl/ssr_checker.sv
bench/testbench.sv
